// ----- rtl/tea_pkg.sv -----
// Shared types, constants and the round mix function for the TEA cipher unit.
// No dependencies; imported by tea_half_round and tea_block_cipher_unit.
package tea_pkg;

   localparam logic [31:0] DELTA = 32'h9e37_79b9;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam int          CSR_INDEX_W = 2;
   localparam logic [1:0]  CSR_KEY_A   = 2'd0;
   localparam logic [1:0]  CSR_KEY_B   = 2'd1;
   localparam logic [1:0]  CSR_KEY_C   = 2'd2;
   localparam logic [1:0]  CSR_KEY_D   = 2'd3;

   typedef struct packed {
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] k2;
      logic [31:0] k3;
   } key_type;

   typedef struct packed {
      logic        valid;
      logic        cmd;
      logic [31:0] first;
      logic [31:0] second;
   } stage_type;

   function automatic logic [31:0] tea_mix(input logic [31:0] w, input logic [31:0] sum,
                                           input logic [31:0] ka, input logic [31:0] kb);
      tea_mix = ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

endpackage

// ----- rtl/tea_half_round.sv -----
// One pipeline stage of the TEA cipher: half of a round, updating one word.
// Depends on tea_pkg for the stage/key types and the mix function.
module tea_half_round
   import tea_pkg::*;
#(
   parameter logic [31:0] SUM_ENC     = 32'h0,
   parameter logic [31:0] SUM_DEC     = 32'h0,
   parameter bit          SECOND_HALF = 1'b0
) (
   input  logic      clock,
   input  logic      reset,
   input  key_type   key,
   input  stage_type stage_in,
   output stage_type stage_out
);

   logic        upd_first;
   logic [31:0] src;
   logic [31:0] dst;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] sum;
   logic [31:0] mixed;
   logic [31:0] res;

   logic        valid_ff;
   logic        valid_in;
   logic        cmd_ff;
   logic [31:0] first_ff;
   logic [31:0] second_ff;
   logic [31:0] first_in;
   logic [31:0] second_in;

   // encrypt touches the first word in its first half, decrypt in its second
   assign upd_first = (stage_in.cmd == CMD_ENCRYPT) ? !SECOND_HALF : SECOND_HALF;

   always_comb begin
      src   = upd_first ? stage_in.second : stage_in.first;
      dst   = upd_first ? stage_in.first  : stage_in.second;
      ka    = upd_first ? key.k0 : key.k2;
      kb    = upd_first ? key.k1 : key.k3;
      sum   = (stage_in.cmd == CMD_ENCRYPT) ? SUM_ENC : SUM_DEC;
      mixed = tea_mix(src, sum, ka, kb);
      res   = (stage_in.cmd == CMD_ENCRYPT) ? dst + mixed : dst - mixed;
   end

   assign valid_in  = stage_in.valid;
   assign first_in  = upd_first ? res : stage_in.first;
   assign second_in = upd_first ? stage_in.second : res;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= stage_in.cmd;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign stage_out = '{valid: valid_ff, cmd: cmd_ff, first: first_ff, second: second_ff};

   a_valid_tracks: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> valid_ff == $past(stage_in.valid))
      else $error("stage valid lost or invented");

   a_cmd_tracks: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !$past(reset) |-> cmd_ff == $past(stage_in.cmd))
      else $error("stage command corrupted");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !$past(reset) |->
         (first_ff == $past(stage_in.first)) || (second_ff == $past(stage_in.second)))
      else $error("stage changed both words");

endmodule

// ----- rtl/tea_block_cipher_unit.sv -----
// Top level of the TEA block cipher unit: key registers and the round pipeline.
// Depends on tea_pkg and instantiates tea_half_round once per half round.
//
// Usage:
//   Input: drive req_cmd (0 encrypt, 1 decrypt), req_block_first and
//   req_block_second with start high; the transfer happens at a rising edge
//   where start is high and busy is low. A new block may follow every cycle.
//   Result: rsp_strobe is high for exactly one cycle with rsp_out_first and
//   rsp_out_second; the receiver takes it in that cycle and cannot stall.
//   Throughput: one block per cycle; each block passes through every stage
//   register in order on its way from the input transfer to the strobe.
//   The pipeline has one register stage per half round: each stage applies
//   one mix and one add or subtract to one word, and the round sum of every
//   stage is a constant, so the stage depth sets the clock.
//   Keys: csr_write_en with csr_index 0..3 writes key words a..d. Write keys
//   only while no block is in flight; stages read the key registers directly.
//   Reset: keys clear to zero, every stage valid bit clears, and busy holds
//   high during reset and for one cycle after it.
module tea_block_cipher_unit
   import tea_pkg::*;
#(
   parameter int ROUNDS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic [31:0]            req_block_first,
   input  logic [31:0]            req_block_second,
   output logic                   rsp_strobe,
   output logic [31:0]            rsp_out_first,
   output logic [31:0]            rsp_out_second,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int STAGES = 2 * ROUNDS;

   key_type   key_ff;
   key_type   key_in;
   logic      busy_ff;
   stage_type pipe [STAGES+1];

   // key registers: plain write port, writes are registered into key_ff
   always_comb begin
      key_in = key_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_A: key_in.k0 = csr_wdata;
            CSR_KEY_B: key_in.k1 = csr_wdata;
            CSR_KEY_C: key_in.k2 = csr_wdata;
            CSR_KEY_D: key_in.k3 = csr_wdata;
            default:   key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         key_ff  <= key_in;
         busy_ff <= 1'b0;
      end
   end

   // hold off transfers while reset is active and in the cycle after it
   assign busy = busy_ff | reset;

   assign pipe[0] = '{valid: start & ~busy, cmd: req_cmd,
                      first: req_block_first, second: req_block_second};

   // stage s runs half (s % 2) of round (s / 2); the running sum of a round
   // is fixed per stage, counted up for encrypt and down for decrypt
   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int          RND     = s / 2;
      localparam logic [31:0] SUM_ENC = 32'(64'(DELTA) * 64'(RND + 1));
      localparam logic [31:0] SUM_DEC = 32'(64'(DELTA) * 64'(ROUNDS - RND));

      tea_half_round #(
         .SUM_ENC    (SUM_ENC),
         .SUM_DEC    (SUM_DEC),
         .SECOND_HALF((s % 2) == 1)
      ) u_half (
         .clock    (clock),
         .reset    (reset),
         .key      (key_ff),
         .stage_in (pipe[s]),
         .stage_out(pipe[s+1])
      );
   end

   // last stage register drives the result ports directly
   assign rsp_strobe     = pipe[STAGES].valid;
   assign rsp_out_first  = pipe[STAGES].first;
   assign rsp_out_second = pipe[STAGES].second;

   a_busy_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> busy)
      else $error("busy not held the cycle after reset");

   a_busy_clears: assert property (@(posedge clock)
      !reset && !$past(reset) |-> !busy)
      else $error("busy stuck high outside reset");

   a_flush_on_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

endmodule
